### rtl/core/plic_pkg.sv
package plic_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_SOURCES_DEF   = 64;
    localparam int PRIORITY_BITS_DEF = 3;

    // Fixed widths of the bus fields.
    localparam int WORD_BITS = 32;
    localparam int INDEX_W   = 6;
    localparam int THRESH_W  = 3;

    // Bit positions inside one source entry of the state memory.
    // The priority sits above the three flag bits.
    localparam int FLT_BIT  = 0;
    localparam int PEND_BIT = 1;
    localparam int EN_BIT   = 2;
    localparam int PRIO_LSB = 3;

    typedef enum logic [1:0] {
        ACT_READ    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_REQUEST = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        BLK_PRIO    = 2'd0,
        BLK_PENDING = 2'd1,
        BLK_ENABLE  = 2'd2,
        BLK_CLAIM   = 2'd3
    } block_t;

    typedef struct packed {
        action_t                action;
        block_t                 reg_block;
        logic [INDEX_W-1:0]     index;
        logic [WORD_BITS-1:0]   write_data;
    } item_t;

    typedef struct packed {
        logic                   done;
        logic [WORD_BITS-1:0]   read_data;
        logic                   irq;
        logic                   bad;
    } result_t;

endpackage

### rtl/core/platform_interrupt_controller_unit.sv
// Single-target platform-level interrupt controller.
//
// Commands: an operation (bus read, bus write or source request) is taken
// at a rising edge with start high and busy low. Its result appears on
// read_data, interrupt_line and bad_access, marked by done for exactly one
// cycle; the receiver cannot hold results off and nothing here waits on it.
// interrupt_line reflects the state after the operation has been applied.
//
// All per-source state (priority, enable, pending, in-flight) lives in one
// synchronous memory of NUM_SOURCES entries. An operation sweeps that
// memory, reading, updating and writing back one entry per cycle and
// ranking the entries for the interrupt line as it goes; a claim read
// needs a ranking sweep before the update sweep. The single memory port
// pair sets this pace. busy falls in the cycle in which done is shown.
//
// After reset the block clears the memory, one entry per cycle, with busy
// high. The threshold write channel is always ready and is taken as soon as
// it is offered; it is reset to zero.
module platform_interrupt_controller_unit
    import plic_pkg::*;
#(
    parameter int NUM_SOURCES   = NUM_SOURCES_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           action,
    input  logic [1:0]           reg_block,
    input  logic [INDEX_W-1:0]   index,
    input  logic [WORD_BITS-1:0] write_data,
    output logic                 done,
    output logic [WORD_BITS-1:0] read_data,
    output logic                 interrupt_line,
    output logic                 bad_access,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [THRESH_W-1:0]  cfg_data
);

    localparam int SRC_W   = $clog2(NUM_SOURCES);
    localparam int ENTRY_W = PRIORITY_BITS + 3;

    logic [THRESH_W-1:0] threshold_reg, threshold_next;
    item_t               item;
    result_t             result;
    logic                seq_busy;
    logic                ram_we;
    logic [SRC_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [SRC_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    // The threshold register is the only configuration state, always ready;
    // software is to make changes only between operations; unenforced.
    assign cfg_ready      = 1'b1;
    assign threshold_next = (cfg_valid && cfg_ready) ? cfg_data : threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    // Gather the command fields into one item for the sequencer.
    always_comb
    begin
        item.action     = action_t'(action);
        item.reg_block  = block_t'(reg_block);
        item.index      = index;
        item.write_data = write_data;
    end

    plic_seq #(
        .NUM_SOURCES   (NUM_SOURCES),
        .PRIORITY_BITS (PRIORITY_BITS),
        .SRC_W         (SRC_W),
        .ENTRY_W       (ENTRY_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start && !seq_busy),
        .item      (item),
        .threshold (threshold_reg),
        .busy      (seq_busy),
        .result    (result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    plic_ram #(
        .DEPTH  (NUM_SOURCES),
        .WIDTH  (ENTRY_W),
        .ADDR_W (SRC_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The result register inside the sequencer drives the ports directly.
    assign busy           = seq_busy;
    assign done           = result.done;
    assign read_data      = result.read_data;
    assign interrupt_line = result.irq;
    assign bad_access     = result.bad;

endmodule

### rtl/core/plic_ram.sv
module plic_ram
    import plic_pkg::*;
#(
    parameter int DEPTH  = NUM_SOURCES_DEF,
    parameter int WIDTH  = PRIORITY_BITS_DEF + 3,
    parameter int ADDR_W = $clog2(NUM_SOURCES_DEF)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/plic_seq.sv
module plic_seq
    import plic_pkg::*;
#(
    parameter int NUM_SOURCES   = NUM_SOURCES_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
    parameter int SRC_W         = $clog2(NUM_SOURCES_DEF),
    parameter int ENTRY_W       = PRIORITY_BITS_DEF + 3
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  item_t               item,
    input  logic [THRESH_W-1:0] threshold,
    output logic                busy,
    output result_t             result,
    output logic                ram_we,
    output logic [SRC_W-1:0]    ram_waddr,
    output logic [ENTRY_W-1:0]  ram_wdata,
    output logic [SRC_W-1:0]    ram_raddr,
    input  logic [ENTRY_W-1:0]  ram_rdata
);

    localparam int CNT_W     = $clog2(NUM_SOURCES + 1);
    localparam int NUM_WORDS = (NUM_SOURCES + WORD_BITS - 1) / WORD_BITS;
    localparam int BP_W      = (PRIORITY_BITS > THRESH_W) ? PRIORITY_BITS : THRESH_W;
    localparam int EXT_W     = 16;
    localparam int SEL_W     = $clog2(WORD_BITS);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 rvalid_reg, rvalid_next;
    logic [SRC_W-1:0]     raddr_q_reg, raddr_q_next;
    item_t                item_reg, item_next;
    logic                 bad_reg, bad_next;
    logic [SRC_W-1:0]     claim_id_reg, claim_id_next;
    logic [SRC_W-1:0]     best_id_reg, best_id_next;
    logic [BP_W-1:0]      best_pri_reg, best_pri_next;
    logic [WORD_BITS-1:0] rdata_reg, rdata_next;
    result_t              result_reg, result_next;

    logic                 issue;
    logic                 last;
    logic                 is_claim_rd;
    logic                 start_bad;
    logic                 src_bad;
    logic                 word_bad;
    logic [EXT_W-1:0]     a_ext;
    logic [SEL_W-1:0]     bitpos;
    logic                 word_hit;
    logic [SRC_W-1:0]     tgt_idx;
    logic [SRC_W-1:0]     tgt_cpl;
    logic [ENTRY_W-1:0]   ent;
    logic [ENTRY_W-1:0]   ent_new;
    logic [ENTRY_W-1:0]   cand;
    logic [BP_W-1:0]      cand_pri;
    logic                 hit;

    // Error checks on an item, evaluated as it is taken in.
    always_comb
    begin
        src_bad  = (item.index == '0) ||
                   (32'(item.index) >= 32'(NUM_SOURCES));
        word_bad = 32'(item.index) >= 32'(NUM_WORDS);
        start_bad = 1'b0;
        case (item.action)
            ACT_REQUEST:
            begin
                start_bad = src_bad;
            end
            ACT_READ, ACT_WRITE:
            begin
                case (item.reg_block)
                    BLK_PRIO:
                    begin
                        start_bad = src_bad;
                    end
                    BLK_PENDING, BLK_ENABLE:
                    begin
                        start_bad = word_bad;
                    end
                    BLK_CLAIM:
                    begin
                        start_bad = (item.action == ACT_WRITE) &&
                                    ((item.write_data == '0) ||
                                     (item.write_data >= 32'(NUM_SOURCES)));
                    end
                    default:
                    begin
                        start_bad = 1'b0;
                    end
                endcase
            end
            default:
            begin
                start_bad = 1'b0;
            end
        endcase
    end

    // Per-entry read-modify-write on the entry returned by the memory.
    always_comb
    begin
        ent      = ram_rdata;
        a_ext    = EXT_W'(raddr_q_reg);
        bitpos   = a_ext[SEL_W-1:0];
        word_hit = (a_ext[EXT_W-1:SEL_W] == (EXT_W - SEL_W)'(item_reg.index)) &&
                   (raddr_q_reg != '0);
        tgt_idx  = SRC_W'(item_reg.index);
        tgt_cpl  = SRC_W'(item_reg.write_data);
        is_claim_rd = (item_reg.action == ACT_READ) && (item_reg.reg_block == BLK_CLAIM);

        ent_new    = ent;
        rdata_next = rdata_reg;
        if (!bad_reg)
        begin
            case (item_reg.action)
                ACT_REQUEST:
                begin
                    if ((raddr_q_reg == tgt_idx) && !ent[FLT_BIT])
                    begin
                        ent_new[PEND_BIT] = 1'b1;
                    end
                end
                ACT_WRITE:
                begin
                    case (item_reg.reg_block)
                        BLK_PRIO:
                        begin
                            if (raddr_q_reg == tgt_idx)
                            begin
                                ent_new[PRIO_LSB +: PRIORITY_BITS] =
                                    item_reg.write_data[PRIORITY_BITS-1:0];
                            end
                        end
                        BLK_ENABLE:
                        begin
                            if (word_hit)
                            begin
                                ent_new[EN_BIT] = item_reg.write_data[bitpos];
                            end
                        end
                        BLK_CLAIM:
                        begin
                            if ((raddr_q_reg == tgt_cpl) && ent[EN_BIT])
                            begin
                                ent_new[FLT_BIT] = 1'b0;
                            end
                        end
                        default:
                        begin
                            ent_new = ent;
                        end
                    endcase
                end
                ACT_READ:
                begin
                    case (item_reg.reg_block)
                        BLK_PRIO:
                        begin
                            if (raddr_q_reg == tgt_idx)
                            begin
                                rdata_next = WORD_BITS'(ent[PRIO_LSB +: PRIORITY_BITS]);
                            end
                        end
                        BLK_PENDING:
                        begin
                            if (word_hit)
                            begin
                                rdata_next = rdata_reg |
                                             (WORD_BITS'(ent[PEND_BIT]) << bitpos);
                            end
                        end
                        BLK_ENABLE:
                        begin
                            if (word_hit)
                            begin
                                rdata_next = rdata_reg |
                                             (WORD_BITS'(ent[EN_BIT]) << bitpos);
                            end
                        end
                        BLK_CLAIM:
                        begin
                            if ((claim_id_reg != '0) && (raddr_q_reg == claim_id_reg))
                            begin
                                ent_new[PEND_BIT] = 1'b0;
                                ent_new[FLT_BIT]  = 1'b1;
                            end
                        end
                        default:
                        begin
                            ent_new = ent;
                        end
                    endcase
                end
                default:
                begin
                    ent_new = ent;
                end
            endcase
        end
        if ((state_reg != ST_UPDATE) || !rvalid_reg)
        begin
            rdata_next = rdata_reg;
        end

        // The scan pass ranks the stored entries, the update pass the new ones.
        cand     = (state_reg == ST_SCAN) ? ent : ent_new;
        cand_pri = BP_W'(cand[PRIO_LSB +: PRIORITY_BITS]);
        hit      = rvalid_reg && (raddr_q_reg != '0) && cand[PEND_BIT] &&
                   cand[EN_BIT] && (cand_pri > best_pri_reg);
    end

    assign issue = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE)) &&
                   (cnt_reg < CNT_W'(NUM_SOURCES));
    assign last  = rvalid_reg && (raddr_q_reg == SRC_W'(NUM_SOURCES - 1));

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rvalid_next   = issue;
        raddr_q_next  = cnt_reg[SRC_W-1:0];
        item_next     = item_reg;
        bad_next      = bad_reg;
        claim_id_next = claim_id_reg;
        best_id_next  = hit ? raddr_q_reg : best_id_reg;
        best_pri_next = hit ? cand_pri : best_pri_reg;
        result_next   = result_reg;
        result_next.done = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = raddr_q_reg;
        ram_wdata = ent_new;
        ram_raddr = cnt_reg[SRC_W-1:0];

        if (issue)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[SRC_W-1:0];
                ram_wdata = '0;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_SOURCES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next     = item;
                    bad_next      = start_bad;
                    cnt_next      = '0;
                    claim_id_next = '0;
                    best_id_next  = '0;
                    best_pri_next = BP_W'(threshold);
                    if ((item.action == ACT_READ) && (item.reg_block == BLK_CLAIM))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (last)
                begin
                    claim_id_next = best_id_next;
                    state_next    = ST_UPDATE;
                    cnt_next      = '0;
                    best_id_next  = '0;
                    best_pri_next = BP_W'(threshold);
                end
            end
            ST_UPDATE:
            begin
                ram_we = rvalid_reg;
                if (last)
                begin
                    result_next.done      = 1'b1;
                    result_next.read_data = is_claim_rd ? WORD_BITS'(claim_id_reg)
                                                        : rdata_next;
                    result_next.irq       = (best_id_next != '0);
                    result_next.bad       = bad_reg;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            rvalid_reg   <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rvalid_reg   <= rvalid_next;
            result_reg   <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_q_reg  <= raddr_q_next;
        item_reg     <= item_next;
        bad_reg      <= bad_next;
        claim_id_reg <= claim_id_next;
        best_id_reg  <= best_id_next;
        best_pri_reg <= best_pri_next;
        if ((state_reg == ST_IDLE) && start)
        begin
            rdata_reg <= '0;
        end
        else
        begin
            rdata_reg <= rdata_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign result = result_reg;

endmodule

### rtl/core/plic_checker.sv
module plic_checker
    import plic_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [WORD_BITS-1:0] read_data,
    input logic                 bad_access
);

    // A result is only shown once the block has gone idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // An accepted operation always occupies the block for its sweep.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("operation accepted but block not busy");

    // Each transfer lasts one cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for two cycles");

    // A rejected access never returns data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_access) |-> (read_data == '0))
        else $error("rejected access returned data");

endmodule

bind platform_interrupt_controller_unit plic_checker u_plic_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .read_data  (read_data),
    .bad_access (bad_access)
);

### sim/platform_interrupt_controller_unit_tb.sv
`timescale 1ns / 100ps

module platform_interrupt_controller_unit_tb;
    import plic_pkg::*;

    // Operations are offered on the command port and every accepted transfer
    // is run through a behavioural model of the controller kept in this file.
    // The model holds its own copy of the per-source priority, enable, pending
    // and in-flight state and of the threshold. Each accepted operation yields
    // exactly one expected reply, queued in order. The reply monitor compares
    // every done strobe with the oldest queued reply, field by field.

    localparam int NSRC      = NUM_SOURCES_DEF;
    localparam int PRIO_W    = PRIORITY_BITS_DEF;
    localparam int NWORDS    = (NSRC + WORD_BITS - 1) / WORD_BITS;
    localparam int PHASES    = 8;
    localparam int PHASE_OPS = 200;

    // One expected reply of the controller.
    typedef struct packed {
        logic [WORD_BITS-1:0] read_data;
        logic                 irq;
        logic                 bad;
    } bus_reply_t;

    // One row of the directed sequence. Where pinned is set, the reply is
    // typed in by hand; otherwise it comes from the model.
    typedef struct packed {
        action_t              act;
        block_t               blk;
        logic [INDEX_W-1:0]   idx;
        logic [WORD_BITS-1:0] wdata;
        logic                 pinned;
        logic [WORD_BITS-1:0] rd;
        logic                 irq;
        logic                 bad;
    } directed_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    action_t              action = ACT_READ;
    block_t               reg_block = BLK_PRIO;
    logic [INDEX_W-1:0]   index = '0;
    logic [WORD_BITS-1:0] write_data = '0;
    logic                 done;
    logic [WORD_BITS-1:0] read_data;
    logic                 interrupt_line;
    logic                 bad_access;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [THRESH_W-1:0]  cfg_data = '0;

    // Model state.
    logic [PRIO_W-1:0]    prio_mem [NSRC];
    logic [NSRC-1:0]      enable_bits;
    logic [NSRC-1:0]      pending_bits;
    logic [NSRC-1:0]      flight_bits;
    logic [THRESH_W-1:0]  mask_level;

    bus_reply_t           reply_q [$];
    int                   err_count = 0;
    int                   ops_issued = 0;
    int                   claims_granted = 0;
    int                   irq_replies = 0;
    int                   burst_left = 0;

    // The directed sequence starts from the reset state with the threshold
    // at zero. It walks the source-zero and out-of-range cases, the wide
    // priority write, dropped enable bits, the read-only pending word, a
    // priority tie, a request while in flight, bad and disabled completions
    // and the unused action.
    directed_row_t directed_ops [0:26] = '{
        '{ACT_READ,    BLK_PRIO,    6'd0,  32'h0,        1'b1, 32'h0,        1'b0, 1'b1},
        '{ACT_WRITE,   BLK_PRIO,    6'd0,  32'h7,        1'b1, 32'h0,        1'b0, 1'b1},
        '{ACT_WRITE,   BLK_PRIO,    6'd63, 32'hFFFF_FFFF, 1'b1, 32'h0,       1'b0, 1'b0},
        '{ACT_READ,    BLK_PRIO,    6'd63, 32'h1234_5678, 1'b1, 32'h7,       1'b0, 1'b0},
        '{ACT_WRITE,   BLK_PRIO,    6'd32, 32'h7,        1'b1, 32'h0,        1'b0, 1'b0},
        '{ACT_WRITE,   BLK_PRIO,    6'd1,  32'h9,        1'b1, 32'h0,        1'b0, 1'b0},
        '{ACT_REQUEST, BLK_CLAIM,   6'd0,  32'h0,        1'b1, 32'h0,        1'b0, 1'b1},
        '{ACT_REQUEST, BLK_PRIO,    6'd63, 32'h0,        1'b1, 32'h0,        1'b0, 1'b0},
        '{ACT_READ,    BLK_PENDING, 6'd1,  32'h0,        1'b1, 32'h8000_0000, 1'b0, 1'b0},
        '{ACT_WRITE,   BLK_PENDING, 6'd0,  32'hFFFF_FFFF, 1'b1, 32'h0,       1'b0, 1'b0},
        '{ACT_READ,    BLK_PENDING, 6'd2,  32'h0,        1'b1, 32'h0,        1'b0, 1'b1},
        '{ACT_WRITE,   BLK_ENABLE,  6'd0,  32'hFFFF_FFFF, 1'b0, 32'h0,       1'b0, 1'b0},
        '{ACT_WRITE,   BLK_ENABLE,  6'd1,  32'hFFFF_FFFF, 1'b0, 32'h0,       1'b0, 1'b0},
        '{ACT_READ,    BLK_ENABLE,  6'd0,  32'h0,        1'b1, 32'hFFFF_FFFE, 1'b1, 1'b0},
        '{ACT_WRITE,   BLK_ENABLE,  6'd63, 32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
        '{ACT_REQUEST, BLK_ENABLE,  6'd32, 32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
        '{ACT_REQUEST, BLK_PRIO,    6'd1,  32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
        '{ACT_READ,    BLK_CLAIM,   6'd45, 32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
        '{ACT_REQUEST, BLK_PRIO,    6'd32, 32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
        '{ACT_WRITE,   BLK_CLAIM,   6'd0,  32'h0,        1'b1, 32'h0,        1'b1, 1'b1},
        '{ACT_WRITE,   BLK_CLAIM,   6'd7,  32'hFFFF_FFFF, 1'b1, 32'h0,       1'b1, 1'b1},
        '{ACT_WRITE,   BLK_ENABLE,  6'd1,  32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
        '{ACT_WRITE,   BLK_CLAIM,   6'd0,  32'd32,       1'b0, 32'h0,        1'b0, 1'b0},
        '{ACT_WRITE,   BLK_ENABLE,  6'd1,  32'h1,        1'b0, 32'h0,        1'b0, 1'b0},
        '{ACT_WRITE,   BLK_CLAIM,   6'd0,  32'd32,       1'b0, 32'h0,        1'b0, 1'b0},
        '{ACT_READ,    BLK_CLAIM,   6'd0,  32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
        '{ACT_NONE,    BLK_CLAIM,   6'd63, 32'hFFFF_FFFF, 1'b0, 32'h0,       1'b0, 1'b0}
    };

    platform_interrupt_controller_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .reg_block      (reg_block),
        .index          (index),
        .write_data     (write_data),
        .done           (done),
        .read_data      (read_data),
        .interrupt_line (interrupt_line),
        .bad_access     (bad_access),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // The winning source for a claim: enabled, pending, priority strictly
    // above the running best (which starts at the threshold), so a tie
    // keeps the lower ID. Zero means nothing qualifies.
    function automatic int top_source();
        int best;
        int best_pri;
        best = 0;
        best_pri = int'(mask_level);
        for (int id = 1; id < NSRC; id++)
        begin
            if (pending_bits[id] && enable_bits[id] && int'(prio_mem[id]) > best_pri)
            begin
                best = id;
                best_pri = int'(prio_mem[id]);
            end
        end
        return best;
    endfunction

    // Applies one operation to the model state and returns its reply.
    function automatic bus_reply_t apply_op(item_t op);
        bus_reply_t rep;
        int         id;
        int         base;
        rep = '0;
        if (op.action == ACT_REQUEST)
        begin
            if (op.index == 0)
                rep.bad = 1'b1;
            else if (!flight_bits[op.index])
                pending_bits[op.index] = 1'b1;
        end
        else if (op.action == ACT_READ || op.action == ACT_WRITE)
        begin
            case (op.reg_block)
                BLK_PRIO:
                begin
                    if (op.index == 0)
                        rep.bad = 1'b1;
                    else if (op.action == ACT_WRITE)
                        prio_mem[op.index] = op.write_data[PRIO_W-1:0];
                    else
                        rep.read_data = WORD_BITS'(prio_mem[op.index]);
                end
                BLK_PENDING:
                begin
                    // Pending is read-only; a write to a real word is
                    // accepted silently.
                    if (op.index >= NWORDS)
                        rep.bad = 1'b1;
                    else if (op.action == ACT_READ)
                        rep.read_data = pending_bits[op.index*WORD_BITS +: WORD_BITS];
                end
                BLK_ENABLE:
                begin
                    if (op.index >= NWORDS)
                        rep.bad = 1'b1;
                    else if (op.action == ACT_WRITE)
                    begin
                        // The bit for source zero is dropped.
                        base = op.index * WORD_BITS;
                        for (int b = 0; b < WORD_BITS; b++)
                            if (base + b != 0)
                                enable_bits[base + b] = op.write_data[b];
                    end
                    else
                        rep.read_data = enable_bits[op.index*WORD_BITS +: WORD_BITS];
                end
                default:
                begin
                    if (op.action == ACT_WRITE)
                    begin
                        // Completion releases the source only if enabled.
                        if (op.write_data == 0 || op.write_data >= NSRC)
                            rep.bad = 1'b1;
                        else if (enable_bits[op.write_data])
                            flight_bits[op.write_data] = 1'b0;
                    end
                    else
                    begin
                        id = top_source();
                        if (id != 0)
                        begin
                            pending_bits[id] = 1'b0;
                            flight_bits[id] = 1'b1;
                            claims_granted++;
                        end
                        rep.read_data = id;
                    end
                end
            endcase
        end
        rep.irq = (top_source() != 0);
        return rep;
    endfunction

    // Idle cycles after an operation: nothing inside a burst, then a short
    // or now and again a long gap so that offers land on every phase of the
    // controller's sweep.
    function automatic int next_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 15);
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(20, 140);
        return $urandom_range(1, 6);
    endfunction

    // An in-flight source if one of up to 33 random picks hits one, else any real source.
    function automatic logic [WORD_BITS-1:0] completion_id();
        int tries;
        int id;
        tries = 0;
        id = $urandom_range(1, NSRC - 1);
        while (!flight_bits[id] && tries < 32)
        begin
            id = $urandom_range(1, NSRC - 1);
            tries++;
        end
        return id;
    endfunction

    // Random operation. Most of the mix is the life cycle of an interrupt
    // (priority set, enable, request, claim, complete) so that sources move
    // through all their states; the rest is reads, rejected accesses, the
    // unused action and pure noise.
    function automatic item_t random_op();
        item_t op;
        int    roll;
        op.action = action_t'($urandom_range(0, 3));
        op.reg_block = block_t'($urandom_range(0, 3));
        op.index = INDEX_W'($urandom_range(0, NSRC - 1));
        op.write_data = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 28)
        begin
            op.action = ACT_REQUEST;
            op.index = ($urandom_range(0, 19) == 0) ? '0
                                                    : INDEX_W'($urandom_range(1, NSRC - 1));
        end
        else if (roll < 42)
        begin
            op.action = ACT_READ;
            op.reg_block = BLK_CLAIM;
        end
        else if (roll < 56)
        begin
            op.action = ACT_WRITE;
            op.reg_block = BLK_CLAIM;
            case ($urandom_range(0, 11))
                0: op.write_data = 0;
                1: op.write_data = $urandom_range(NSRC, 200);
                2: op.write_data = $urandom;
                default: op.write_data = completion_id();
            endcase
        end
        else if (roll < 66)
        begin
            op.action = ACT_WRITE;
            op.reg_block = BLK_PRIO;
        end
        else if (roll < 71)
        begin
            op.action = ACT_READ;
            op.reg_block = BLK_PRIO;
        end
        else if (roll < 89)
        begin
            op.action = (roll < 77 || roll >= 86) ? ACT_WRITE : ACT_READ;
            op.reg_block = (roll < 81) ? BLK_ENABLE : BLK_PENDING;
            if ($urandom_range(0, 7) != 0)
                op.index = INDEX_W'($urandom_range(0, NWORDS - 1));
        end
        else if (roll < 92)
        begin
            op.action = ACT_NONE;
        end
        return op;
    endfunction

    // Offers one operation and waits for its transfer. The reply is worked
    // out at the accepting edge; a pinned reply replaces the model's while
    // the model state still moves on.
    task automatic issue_op(input item_t op, input logic pinned, input bus_reply_t fixed);
        bus_reply_t rep;
        int         gap;
        @(negedge clk);
        start <= 1'b1;
        action <= op.action;
        reg_block <= op.reg_block;
        index <= op.index;
        write_data <= op.write_data;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rep = apply_op(op);
        reply_q.push_back(pinned ? fixed : rep);
        ops_issued++;
        gap = next_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // Threshold write, made only once every reply is in and the controller
    // is idle.
    task automatic set_threshold(input logic [THRESH_W-1:0] level);
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (reply_q.size() != 0 || busy)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= level;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mask_level = level;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Reply monitor: every done strobe must match the oldest expectation.
    always @(posedge clk)
    begin
        bus_reply_t want;
        if (rst_n && done === 1'b1)
        begin
            if (reply_q.size() == 0)
            begin
                $error("reply with no operation outstanding");
                err_count++;
            end
            else
            begin
                want = reply_q.pop_front();
                if (want.irq)
                    irq_replies++;
                if (read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, got %h", want.read_data, read_data);
                    err_count++;
                end
                if (interrupt_line !== want.irq)
                begin
                    $error("interrupt_line: expected %b, got %b", want.irq, interrupt_line);
                    err_count++;
                end
                if (bad_access !== want.bad)
                begin
                    $error("bad_access: expected %b, got %b", want.bad, bad_access);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        item_t      op;
        bus_reply_t fixed;
        int         plan [PHASES];
        plan = '{0, 7, 3, 1, 6, 0, 5, 2};
        plan[5] = $urandom_range(0, 7);

        for (int i = 0; i < NSRC; i++)
            prio_mem[i] = '0;
        enable_bits = '0;
        pending_bits = '0;
        flight_bits = '0;
        mask_level = '0;

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, run from the reset threshold of zero. The first
        // offer simply waits out the clearing sweep that follows reset.
        foreach (directed_ops[i])
        begin
            op.action = directed_ops[i].act;
            op.reg_block = directed_ops[i].blk;
            op.index = directed_ops[i].idx;
            op.write_data = directed_ops[i].wdata;
            fixed.read_data = directed_ops[i].rd;
            fixed.irq = directed_ops[i].irq;
            fixed.bad = directed_ops[i].bad;
            issue_op(op, directed_ops[i].pinned, fixed);
        end

        // Random part, one phase per threshold setting, the extremes among
        // them.
        for (int p = 0; p < PHASES; p++)
        begin
            set_threshold(THRESH_W'(plan[p]));
            for (int n = 0; n < PHASE_OPS; n++)
                issue_op(random_op(), 1'b0, '0);
        end

        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (reply_q.size() != 0)
            @(posedge clk);
        // Allow for a stray strobe after the last claim-length sweep.
        repeat (2 * NSRC + 10)
            @(posedge clk);

        $display("Ran %0d operations over %0d threshold settings.", ops_issued, PHASES + 1);
        $display("%0d claims granted a source; %0d replies had the interrupt raised.",
                 claims_granted, irq_replies);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #50_000_000;
        $display("Timed out with %0d replies outstanding.", reply_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
